FILE: design/stlb_pkg.sv
// Shared types, constants, microcode and fixed-point helpers of the torque-limit barrier unit.
`timescale 1ns / 1ps
package stlb_pkg;

  localparam int JOINTS  = 32;
  localparam int JOINT_W = 5;
  localparam int NORM_W  = 47;
  localparam int PC_W    = 6;

  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam logic signed [31:0] EPS_Q = 32'sd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic [NORM_W-1:0]  NORM_MAX = '1;

  localparam logic [30:0] BARRIER_RST = 31'd66;
  localparam logic [30:0] STEP_RST    = 31'd655;

  typedef enum logic [2:0] {
    OP_LIMIT    = 3'd0,
    OP_SEED     = 3'd1,
    OP_LINEAR   = 3'd2,
    OP_UPDATE   = 3'd3,
    OP_CONDENSE = 3'd4,
    OP_AUGMENT  = 3'd5,
    OP_NORM     = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  typedef enum logic {
    CFG_BARRIER = 1'b0,
    CFG_STEP    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint_out;
    logic signed [31:0] diag_add;
    logic signed [31:0] grad_add;
    logic [NORM_W-1:0]  norm_sum;
    logic               saturated;
  } result_t;

  // micro-op functions of the shared unit
  typedef enum logic [3:0] {
    F_MOV  = 4'd0,
    F_ADD  = 4'd1,
    F_SUB  = 4'd2,
    F_MUL  = 4'd3,
    F_NEG  = 4'd4,
    F_NSUB = 4'd5,
    F_DIV  = 4'd6,
    F_LIFT = 4'd7,
    F_SQRT = 4'd8,
    F_SQI  = 4'd9,
    F_SQA  = 4'd10,
    F_SQA2 = 4'd11,
    F_NRM  = 4'd12
  } uop_fn_t;

  // working register selects
  typedef enum logic [4:0] {
    W_S    = 5'd0,
    W_D    = 5'd1,
    W_M    = 5'd2,
    W_RES  = 5'd3,
    W_FB   = 5'd4,
    W_DS   = 5'd5,
    W_DD   = 5'd6,
    W_T0   = 5'd7,
    W_T1   = 5'd8,
    W_T2   = 5'd9,
    W_R    = 5'd10,
    W_DIAG = 5'd11,
    W_GRAD = 5'd12,
    W_V    = 5'd13,
    W_B    = 5'd14,
    W_DT   = 5'd15,
    W_ONE  = 5'd16,
    W_EPS  = 5'd17,
    W_ZERO = 5'd18
  } wsel_t;

  typedef struct packed {
    uop_fn_t fn;
    wsel_t   a;
    wsel_t   b;
    wsel_t   dst;
    logic    fin;
  } uop_t;

  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [63:0] num;
    logic [31:0] den;
    logic [5:0]  iters;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
    logic [35:0] rem;
  } iter_rsp_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } qres_t;

  function automatic qres_t clamp32(input logic signed [65:0] v);
    qres_t r;
    if (v > 66'(Q_MAX)) begin
      r.sat = 1'b1;
      r.val = Q_MAX;
    end else if (v < 66'(Q_MIN)) begin
      r.sat = 1'b1;
      r.val = Q_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input uop_fn_t fn, input wsel_t a, input wsel_t b,
                              input wsel_t dst, input logic fin);
    uop_t u;
    u.fn  = fn;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    u.fin = fin;
    return u;
  endfunction

  function automatic logic [PC_W-1:0] start_pc(input op_t op);
    logic [PC_W-1:0] p;
    unique case (op)
      OP_LIMIT:    p = 6'd0;
      OP_SEED:     p = 6'd7;
      OP_LINEAR:   p = 6'd12;
      OP_UPDATE:   p = 6'd24;
      OP_CONDENSE: p = 6'd33;
      OP_AUGMENT:  p = 6'd43;
      OP_NORM:     p = 6'd44;
      default:     p = 6'd0;
    endcase
    return p;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // load limit
      6'd0:  u = mk(F_NEG,  W_V,    W_ZERO, W_M,    1'b0);
      6'd1:  u = mk(F_SUB,  W_M,    W_EPS,  W_S,    1'b0);
      6'd2:  u = mk(F_MOV,  W_EPS,  W_ZERO, W_D,    1'b0);
      6'd3:  u = mk(F_MOV,  W_ZERO, W_ZERO, W_RES,  1'b0);
      6'd4:  u = mk(F_MOV,  W_ZERO, W_ZERO, W_FB,   1'b0);
      6'd5:  u = mk(F_MOV,  W_ZERO, W_ZERO, W_DS,   1'b0);
      6'd6:  u = mk(F_MOV,  W_ZERO, W_ZERO, W_DD,   1'b1);
      // seed
      6'd7:  u = mk(F_SUB,  W_V,    W_M,    W_T0,   1'b0);
      6'd8:  u = mk(F_MUL,  W_DT,   W_T0,   W_S,    1'b0);
      6'd9:  u = mk(F_LIFT, W_S,    W_B,    W_S,    1'b0);
      6'd10: u = mk(F_MUL,  W_B,    W_B,    W_T0,   1'b0);
      6'd11: u = mk(F_DIV,  W_T0,   W_S,    W_D,    1'b1);
      // linearize
      6'd12: u = mk(F_SQI,  W_S,    W_ZERO, W_ZERO, 1'b0);
      6'd13: u = mk(F_SQA,  W_D,    W_ZERO, W_ZERO, 1'b0);
      6'd14: u = mk(F_SQA2, W_B,    W_ZERO, W_ZERO, 1'b0);
      6'd15: u = mk(F_SQRT, W_ZERO, W_ZERO, W_R,    1'b0);
      6'd16: u = mk(F_SUB,  W_M,    W_V,    W_T0,   1'b0);
      6'd17: u = mk(F_MUL,  W_DT,   W_T0,   W_RES,  1'b0);
      6'd18: u = mk(F_SUB,  W_R,    W_S,    W_T0,   1'b0);
      6'd19: u = mk(F_SUB,  W_T0,   W_D,    W_FB,   1'b0);
      6'd20: u = mk(F_DIV,  W_S,    W_R,    W_T0,   1'b0);
      6'd21: u = mk(F_SUB,  W_ONE,  W_T0,   W_DS,   1'b0);
      6'd22: u = mk(F_DIV,  W_D,    W_R,    W_T0,   1'b0);
      6'd23: u = mk(F_SUB,  W_ONE,  W_T0,   W_DD,   1'b1);
      // Newton update
      6'd24: u = mk(F_MUL,  W_DT,   W_V,    W_T0,   1'b0);
      6'd25: u = mk(F_SUB,  W_S,    W_T0,   W_T0,   1'b0);
      6'd26: u = mk(F_ADD,  W_RES,  W_T0,   W_RES,  1'b0);
      6'd27: u = mk(F_MUL,  W_DS,   W_RES,  W_T0,   1'b0);
      6'd28: u = mk(F_ADD,  W_T0,   W_FB,   W_T0,   1'b0);
      6'd29: u = mk(F_DIV,  W_T0,   W_DD,   W_T1,   1'b0);
      6'd30: u = mk(F_SUB,  W_S,    W_RES,  W_S,    1'b0);
      6'd31: u = mk(F_ADD,  W_D,    W_T1,   W_D,    1'b0);
      6'd32: u = mk(F_MOV,  W_T1,   W_ZERO, W_DD,   1'b1);
      // condense
      6'd33: u = mk(F_MUL,  W_DT,   W_DT,   W_T0,   1'b0);
      6'd34: u = mk(F_MUL,  W_T0,   W_DS,   W_T0,   1'b0);
      6'd35: u = mk(F_DIV,  W_T0,   W_DD,   W_DIAG, 1'b0);
      6'd36: u = mk(F_ADD,  W_RES,  W_S,    W_T0,   1'b0);
      6'd37: u = mk(F_MUL,  W_DS,   W_T0,   W_T0,   1'b0);
      6'd38: u = mk(F_MUL,  W_DT,   W_T0,   W_T0,   1'b0);
      6'd39: u = mk(F_DIV,  W_T0,   W_DD,   W_T1,   1'b0);
      6'd40: u = mk(F_MUL,  W_DT,   W_FB,   W_T0,   1'b0);
      6'd41: u = mk(F_DIV,  W_T0,   W_DD,   W_T2,   1'b0);
      6'd42: u = mk(F_NSUB, W_T1,   W_T2,   W_GRAD, 1'b1);
      // augment
      6'd43: u = mk(F_NEG,  W_D,    W_ZERO, W_GRAD, 1'b1);
      // norm term
      6'd44: u = mk(F_SUB,  W_M,    W_V,    W_T0,   1'b0);
      6'd45: u = mk(F_MUL,  W_DT,   W_T0,   W_T0,   1'b0);
      6'd46: u = mk(F_ADD,  W_T0,   W_S,    W_RES,  1'b0);
      6'd47: u = mk(F_MUL,  W_S,    W_D,    W_FB,   1'b0);
      6'd48: u = mk(F_NRM,  W_RES,  W_ZERO, W_ZERO, 1'b0);
      6'd49: u = mk(F_NRM,  W_FB,   W_ZERO, W_ZERO, 1'b1);
      default: u = mk(F_MOV, W_ZERO, W_ZERO, W_T2, 1'b1);
    endcase
    return u;
  endfunction

endpackage

FILE: design/stlb_divsqrt.sv
// Shared bit-serial restoring divider and digit-by-digit square root unit.
`timescale 1ns / 1ps
module stlb_divsqrt (
  input  logic                clk,
  input  logic                rst,
  input  stlb_pkg::iter_req_t req,
  output stlb_pkg::iter_rsp_t rsp
);

  logic        busy;
  logic        sq_mode;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [31:0] den;
  logic [35:0] rem;
  logic [47:0] quo;

  logic [35:0] sh_d;
  logic [35:0] sh_s;
  logic [35:0] trial;
  logic        ge_d;
  logic        ge_s;

  always_comb begin
    sh_d  = {rem[34:0], num[63]};
    ge_d  = sh_d >= {4'b0, den};
    sh_s  = {rem[33:0], num[63:62]};
    trial = {2'b0, quo[31:0], 2'b01};
    ge_s  = sh_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy    <= 1'b1;
      cnt     <= req.iters;
      num     <= req.num;
      den     <= req.den;
      sq_mode <= req.sqrt;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 6'd1;
        if (sq_mode) begin
          rem <= ge_s ? (sh_s - trial) : sh_s;
          quo <= {quo[46:0], ge_s};
          num <= {num[61:0], 2'b00};
        end else begin
          rem <= ge_d ? (sh_d - {4'b0, den}) : sh_d;
          quo <= {quo[46:0], ge_d};
          num <= {num[62:0], 1'b0};
        end
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done = busy && (cnt == '0);
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

FILE: design/soft_torque_limit_barrier_unit.sv
// Top level: per-joint soft torque-limit barrier state and its microcoded sequencer.
// Sequence: accept, fetch, the micro-ops in turn, then writeback; a division, the slack
//   lift and the root hold the sequencer in an iterate state until the shared unit is done.
//   The condense op runs three divides.
// One item at a time: item_stall stays high from acceptance until writeback completes.
// Reset (rst, synchronous): all joint state and the norm sum clear to zero,
//   barrier and step_length return to 66 and 655, no result pending.
`timescale 1ns / 1ps
module soft_torque_limit_barrier_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  stlb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output stlb_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [30:0]       cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_ITER  = 5'b01000,
    ST_WBACK = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [30:0] barrier;
  logic [30:0] step_len;

  // per-joint state
  logic signed [31:0] lower_limit       [stlb_pkg::JOINTS];
  logic signed [31:0] slack_store       [stlb_pkg::JOINTS];
  logic signed [31:0] dual_store        [stlb_pkg::JOINTS];
  logic signed [31:0] residual_store    [stlb_pkg::JOINTS];
  logic signed [31:0] fb_residual_store [stlb_pkg::JOINTS];
  logic signed [31:0] slack_derivative  [stlb_pkg::JOINTS];
  logic signed [31:0] dual_derivative   [stlb_pkg::JOINTS];
  logic [stlb_pkg::NORM_W-1:0] norm_acc;

  // latched beat
  stlb_pkg::op_t                  op_q;
  logic [stlb_pkg::JOINT_W-1:0]   joint_q;
  logic                           last_q;

  // working registers
  logic signed [31:0] s, d, m, res, fb, ds, dd, t0, t1, t2, r, diag, grad, v;
  logic [63:0]        acc64;
  logic               sat_q;
  logic [stlb_pkg::PC_W-1:0] pc;

  // shared unit
  stlb_pkg::uop_t       uop;
  logic signed [31:0]   opa, opb, mul_b;
  logic signed [63:0]   prod;
  logic signed [63:0]   rnd;
  logic [31:0]          abs_a, abs_b;
  logic [32:0]          lift_x;
  logic                 lift_need;
  logic [32:0]          lift_add;
  logic [33:0]          lift_sum;
  logic [47:0]          norm_sum_w;
  logic                 launch;
  logic                 step_go;
  stlb_pkg::qres_t      alu;
  stlb_pkg::iter_req_t  ireq;
  stlb_pkg::iter_rsp_t  irsp;

  function automatic logic signed [31:0] rd(input stlb_pkg::wsel_t sel);
    logic signed [31:0] x;
    case (sel)
      stlb_pkg::W_S:    x = s;
      stlb_pkg::W_D:    x = d;
      stlb_pkg::W_M:    x = m;
      stlb_pkg::W_RES:  x = res;
      stlb_pkg::W_FB:   x = fb;
      stlb_pkg::W_DS:   x = ds;
      stlb_pkg::W_DD:   x = dd;
      stlb_pkg::W_T0:   x = t0;
      stlb_pkg::W_T1:   x = t1;
      stlb_pkg::W_T2:   x = t2;
      stlb_pkg::W_R:    x = r;
      stlb_pkg::W_DIAG: x = diag;
      stlb_pkg::W_GRAD: x = grad;
      stlb_pkg::W_V:    x = v;
      stlb_pkg::W_B:    x = $signed({1'b0, barrier});
      stlb_pkg::W_DT:   x = $signed({1'b0, step_len});
      stlb_pkg::W_ONE:  x = stlb_pkg::ONE_Q;
      stlb_pkg::W_EPS:  x = stlb_pkg::EPS_Q;
      default:          x = '0;
    endcase
    return x;
  endfunction

  stlb_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .rsp (irsp)
  );

  // Operand fetch, the one multiplier, and result shaping.
  always_comb begin
    uop   = stlb_pkg::ucode(pc);
    opa   = rd(uop.a);
    opb   = rd(uop.b);
    mul_b = (uop.fn == stlb_pkg::F_MUL) ? opb : opa;
    prod  = 64'(opa) * 64'(mul_b);
    rnd   = (prod + 64'sd32768) >>> 16;   // round half up, floor

    abs_a = opa[31] ? (~opa + 32'd1) : opa;
    abs_b = opb[31] ? (~opb + 32'd1) : opb;

    // slack lift: s = b + ((s - b) mod b) when s < b, b nonzero
    lift_need = (barrier != '0) && (opa < opb);
    lift_x    = {opb[31], opb} - {opa[31], opa};
    lift_add  = (irsp.rem[31:0] == '0) ? 33'd0 : ({1'b0, opb} - {1'b0, irsp.rem[31:0]});
    lift_sum  = {2'b0, opb} + {1'b0, lift_add};

    norm_sum_w = {1'b0, norm_acc} + rnd[47:0];

    launch = 1'b0;
    ireq   = '0;
    alu    = '0;
    unique case (uop.fn)
      stlb_pkg::F_MOV:  alu.val = opa;
      stlb_pkg::F_ADD:  alu = stlb_pkg::clamp32(66'(opa) + 66'(opb));
      stlb_pkg::F_SUB:  alu = stlb_pkg::clamp32(66'(opa) - 66'(opb));
      stlb_pkg::F_MUL:  alu = stlb_pkg::clamp32(66'(rnd));
      stlb_pkg::F_NEG:  alu = stlb_pkg::clamp32(-66'(opa));
      stlb_pkg::F_NSUB: alu = stlb_pkg::clamp32(-66'(opa) - 66'(opb));
      stlb_pkg::F_DIV: begin
        if (opb == '0) begin
          // zero divisor: largest value of the dividend's sign
          alu.sat = 1'b1;
          alu.val = opa[31] ? stlb_pkg::Q_MIN : stlb_pkg::Q_MAX;
        end else begin
          launch     = 1'b1;
          ireq.num   = {abs_a, 32'b0};
          ireq.den   = abs_b;
          ireq.iters = 6'd48;
          if (opa[31] ^ opb[31]) begin
            alu = stlb_pkg::clamp32(-$signed({18'b0, irsp.quo}));
          end else begin
            alu = stlb_pkg::clamp32($signed({18'b0, irsp.quo}));
          end
        end
      end
      stlb_pkg::F_LIFT: begin
        if (lift_need) begin
          launch     = 1'b1;
          ireq.num   = {lift_x, 31'b0};
          ireq.den   = opb;
          ireq.iters = 6'd33;
          alu        = stlb_pkg::clamp32($signed({32'b0, lift_sum}));
        end else begin
          alu.val = opa;
        end
      end
      stlb_pkg::F_SQRT: begin
        launch     = 1'b1;
        ireq.sqrt  = 1'b1;
        ireq.num   = acc64;
        ireq.iters = 6'd32;
        alu        = stlb_pkg::clamp32($signed({34'b0, irsp.quo[31:0]}));
      end
      stlb_pkg::F_NRM:  alu.sat = norm_sum_w > {1'b0, stlb_pkg::NORM_MAX};
      default:          alu = '0;
    endcase
    ireq.start = (state == ST_EXEC) && launch;
    step_go    = ((state == ST_EXEC) && !launch) || ((state == ST_ITER) && irsp.done);
  end

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      norm_acc     <= '0;
      barrier      <= stlb_pkg::BARRIER_RST;
      step_len     <= stlb_pkg::STEP_RST;
      for (int i = 0; i < stlb_pkg::JOINTS; i++) begin
        lower_limit[i]       <= '0;
        slack_store[i]       <= '0;
        dual_store[i]        <= '0;
        residual_store[i]    <= '0;
        fb_residual_store[i] <= '0;
        slack_derivative[i]  <= '0;
        dual_derivative[i]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (stlb_pkg::cfg_reg_t'(cfg_index))
          stlb_pkg::CFG_BARRIER: barrier  <= cfg_data;
          stlb_pkg::CFG_STEP:    step_len <= cfg_data;
        endcase
      end

      // writeback refills the slot itself in the cycle the old beat leaves
      if (result_valid && !result_stall && (state != ST_WBACK)) begin
        result_valid <= 1'b0;
      end

      // micro-op retire
      if (step_go) begin
        sat_q <= sat_q | alu.sat;
        unique case (uop.fn)
          stlb_pkg::F_SQI:  acc64 <= prod;
          stlb_pkg::F_SQA:  acc64 <= acc64 + prod;
          stlb_pkg::F_SQA2: acc64 <= acc64 + {prod[62:0], 1'b0};
          stlb_pkg::F_NRM:  norm_acc <= alu.sat ? stlb_pkg::NORM_MAX
                                                : norm_sum_w[stlb_pkg::NORM_W-1:0];
          default: begin
            case (uop.dst)
              stlb_pkg::W_S:    s    <= alu.val;
              stlb_pkg::W_D:    d    <= alu.val;
              stlb_pkg::W_M:    m    <= alu.val;
              stlb_pkg::W_RES:  res  <= alu.val;
              stlb_pkg::W_FB:   fb   <= alu.val;
              stlb_pkg::W_DS:   ds   <= alu.val;
              stlb_pkg::W_DD:   dd   <= alu.val;
              stlb_pkg::W_T0:   t0   <= alu.val;
              stlb_pkg::W_T1:   t1   <= alu.val;
              stlb_pkg::W_T2:   t2   <= alu.val;
              stlb_pkg::W_R:    r    <= alu.val;
              stlb_pkg::W_DIAG: diag <= alu.val;
              stlb_pkg::W_GRAD: grad <= alu.val;
              default: ;
            endcase
          end
        endcase
        if (uop.fin) begin
          state <= ST_WBACK;
        end else begin
          pc    <= pc + 6'd1;
          state <= ST_EXEC;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            op_q    <= stlb_pkg::op_t'(item.op);
            joint_q <= item.joint;
            last_q  <= item.last;
            v       <= item.value;
            state   <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          s     <= slack_store[joint_q];
          d     <= dual_store[joint_q];
          m     <= lower_limit[joint_q];
          res   <= residual_store[joint_q];
          fb    <= fb_residual_store[joint_q];
          ds    <= slack_derivative[joint_q];
          dd    <= dual_derivative[joint_q];
          diag  <= '0;
          grad  <= '0;
          sat_q <= 1'b0;
          pc    <= stlb_pkg::start_pc(op_q);
          state <= (op_q == stlb_pkg::OP_NONE) ? ST_WBACK : ST_EXEC;
        end
        ST_EXEC: begin
          if (launch) begin
            state <= ST_ITER;
          end
        end
        ST_ITER: ;
        ST_WBACK: begin
          // result register must be free or being taken before the beat is committed
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            result.joint_out <= joint_q;
            result.diag_add  <= diag;
            result.grad_add  <= grad;
            result.norm_sum  <= norm_acc;
            result.saturated <= sat_q;
            if (op_q != stlb_pkg::OP_NONE) begin
              lower_limit[joint_q]       <= m;
              slack_store[joint_q]       <= s;
              dual_store[joint_q]        <= d;
              residual_store[joint_q]    <= res;
              fb_residual_store[joint_q] <= fb;
              slack_derivative[joint_q]  <= ds;
              dual_derivative[joint_q]   <= dd;
            end
            if (last_q) begin
              norm_acc <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/soft_torque_limit_barrier_unit_test.sv
// Self-checking testbench for the soft torque-limit barrier unit.
`timescale 1ns / 1ps
module soft_torque_limit_barrier_unit_test;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  stlb_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  stlb_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [30:0]       cfg_data;

  soft_torque_limit_barrier_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: shadow copy of the per-joint stores and the registers.
  logic signed [31:0] lim_q   [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] slack_q [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] dual_q  [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] res_q   [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] fb_q    [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] ds_q    [stlb_pkg::JOINTS] = '{default: '0};
  logic signed [31:0] dd_q    [stlb_pkg::JOINTS] = '{default: '0};
  logic [stlb_pkg::NORM_W-1:0] norm_q = '0;
  logic [30:0]        barrier_q;
  logic [30:0]        dt_q;
  bit                 sat_flag;

  stlb_pkg::result_t expected_results[$];   // results still owed by the block
  stlb_pkg::item_t   pending_items[$];      // beats waiting to be offered
  stlb_pkg::result_t last_result;           // most recent result beat taken

  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  longint cycles = 0;
  int     hold_left = 0;
  int     send_gap_pct;
  int     recv_stall_pct;
  bit     hold_off;                 // request for a long receiver hold-off

  // ---------------- fixed-point helpers ----------------
  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return stlb_pkg::Q_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return stlb_pkg::Q_MIN;
    end
    return 32'(v);
  endfunction

  // round half up then floor by 2^16; arithmetic shift floors
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return sat32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fdiv(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [95:0] n;
    logic signed [95:0] q;
    if (b == 0) begin
      sat_flag = 1'b1;
      return (a < 0) ? stlb_pkg::Q_MIN : stlb_pkg::Q_MAX;
    end
    n = 96'(a) * 96'sd65536;
    q = n / 96'(b);   // truncates toward zero
    if (q > 96'sd2147483647) begin
      sat_flag = 1'b1;
      return stlb_pkg::Q_MAX;
    end
    if (q < -96'sd2147483648) begin
      sat_flag = 1'b1;
      return stlb_pkg::Q_MIN;
    end
    return 32'(q);
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] fsquare(input logic signed [31:0] a);
    longint p;
    p = longint'(a) * longint'(a) + 64'sd32768;
    return 64'(p >>> 16);
  endfunction

  // Apply one beat to the shadow state, return the result it must produce.
  function automatic stlb_pkg::result_t barrier_step(input stlb_pkg::item_t it);
    stlb_pkg::result_t r;
    int j;
    logic signed [31:0] s, d, m, b, dt, v, t1, t2, rr, stp;
    logic [63:0] sum, root;
    logic [63:0] acc;
    sat_flag = 1'b0;
    j = it.joint;
    b = 32'(barrier_q);
    dt = 32'(dt_q);
    v = it.value;
    r = '0;
    r.joint_out = it.joint;
    if (stlb_pkg::op_t'(it.op) != stlb_pkg::OP_NONE) begin
      s = slack_q[j];
      d = dual_q[j];
      m = lim_q[j];
      case (stlb_pkg::op_t'(it.op))
        stlb_pkg::OP_LIMIT: begin
          m = sat32(-longint'(v));
          lim_q[j] = m;
          slack_q[j] = sat32(longint'(m) - stlb_pkg::EPS_Q);
          dual_q[j] = stlb_pkg::EPS_Q;
          res_q[j] = 0;
          fb_q[j] = 0;
          ds_q[j] = 0;
          dd_q[j] = 0;
        end
        stlb_pkg::OP_SEED: begin
          s = fmul(dt, sat32(longint'(v) - longint'(m)));
          if (b > 0 && s < b) begin
            longint rem;
            rem = (longint'(s) - longint'(b)) % longint'(b);
            if (rem < 0) rem = rem + longint'(b);
            s = sat32(longint'(b) + rem);
          end
          slack_q[j] = s;
          dual_q[j] = fdiv(fmul(b, b), s);
        end
        stlb_pkg::OP_LINEAR: begin
          sum = 64'(longint'(s) * longint'(s)) + 64'(longint'(d) * longint'(d))
              + 2 * 64'(longint'(b) * longint'(b));
          root = int_root(sum);
          if (root > 64'h7fff_ffff) begin
            sat_flag = 1'b1;
            rr = stlb_pkg::Q_MAX;
          end else begin
            rr = 32'(root);
          end
          res_q[j] = fmul(dt, sat32(longint'(m) - longint'(v)));
          fb_q[j] = sat32(longint'(sat32(longint'(rr) - longint'(s))) - longint'(d));
          ds_q[j] = sat32(longint'(stlb_pkg::ONE_Q) - longint'(fdiv(s, rr)));
          dd_q[j] = sat32(longint'(stlb_pkg::ONE_Q) - longint'(fdiv(d, rr)));
        end
        stlb_pkg::OP_UPDATE: begin
          t1 = sat32(longint'(res_q[j])
                     + longint'(sat32(longint'(s) - longint'(fmul(dt, v)))));
          stp = fdiv(sat32(longint'(fmul(ds_q[j], t1)) + longint'(fb_q[j])), dd_q[j]);
          res_q[j] = t1;
          dd_q[j] = stp;
          slack_q[j] = sat32(longint'(s) - longint'(t1));
          dual_q[j] = sat32(longint'(d) + longint'(stp));
        end
        stlb_pkg::OP_CONDENSE: begin
          r.diag_add = fdiv(fmul(fmul(dt, dt), ds_q[j]), dd_q[j]);
          t1 = fdiv(fmul(dt, fmul(ds_q[j], sat32(longint'(res_q[j]) + longint'(s)))),
                    dd_q[j]);
          t2 = fdiv(fmul(dt, fb_q[j]), dd_q[j]);
          r.grad_add = sat32(-longint'(t1) - longint'(t2));
        end
        stlb_pkg::OP_AUGMENT: r.grad_add = sat32(-longint'(d));
        default: begin   // norm term
          t1 = sat32(longint'(fmul(dt, sat32(longint'(m) - longint'(v)))) + longint'(s));
          t2 = fmul(s, d);
          res_q[j] = t1;
          fb_q[j] = t2;
          acc = 64'(norm_q) + fsquare(t1) + fsquare(t2);
          if (acc > 64'(stlb_pkg::NORM_MAX)) begin
            sat_flag = 1'b1;
            acc = 64'(stlb_pkg::NORM_MAX);
          end
          norm_q = acc[stlb_pkg::NORM_W-1:0];
        end
      endcase
    end
    r.norm_sum = norm_q;
    r.saturated = sat_flag;
    if (it.last) norm_q = '0;
    return r;
  endfunction

  function automatic stlb_pkg::item_t mk_item(input stlb_pkg::op_t op, input int j,
                                              input logic signed [31:0] v, input bit lst);
    stlb_pkg::item_t it;
    it.op = op;
    it.joint = j[stlb_pkg::JOINT_W-1:0];
    it.value = v;
    it.last = lst;
    return it;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      last_result = result;
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %p", result);
      end else begin
        stlb_pkg::result_t e;
        e = expected_results.pop_front();
        if (result !== e) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", e, result);
        end
      end
    end
  end

  // ---------------- receiver stall ----------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_off) begin
      hold_left <= 400;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------- sender ----------------
  // Expectations are queued at acceptance, in acceptance order.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(barrier_step(item));
        items_sent <= items_sent + 1;
      end
      // a stalled beat stays put; otherwise offer the next one or idle
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4_000_000) begin
      $display("timeout");
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct {
    stlb_pkg::item_t   it;
    bit                known;   // expected result typed in
    stlb_pkg::result_t want;
  } row_t;

  row_t table_rows[$];

  task automatic add_row(input stlb_pkg::item_t it, input bit known,
                         input stlb_pkg::result_t e);
    row_t rw;
    rw.it = it;
    rw.known = known;
    rw.want = e;
    table_rows.push_back(rw);
  endtask

  function automatic stlb_pkg::result_t zero_res(input int j, input bit sat);
    stlb_pkg::result_t e;
    e = '0;
    e.joint_out = j[stlb_pkg::JOINT_W-1:0];
    e.saturated = sat;
    return e;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input stlb_pkg::cfg_reg_t idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == stlb_pkg::CFG_BARRIER) barrier_q = val;
    else dt_q = val;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      2: return $urandom_range(1) ? stlb_pkg::Q_MAX : stlb_pkg::Q_MIN;
      default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // well-formed pass over a joint: limit, seed, linearize, update, condense, augment, norm
  task automatic queue_sequence(input int j);
    pending_items.push_back(mk_item(stlb_pkg::OP_LIMIT, j, rand_value(), 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_SEED, j, rand_value(), 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_LINEAR, j, rand_value(), 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_UPDATE, j, rand_value(), 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_CONDENSE, j, 0, 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_AUGMENT, j, 0, 1'b0));
    pending_items.push_back(mk_item(stlb_pkg::OP_NORM, j, rand_value(),
                                    $urandom_range(3) == 0));
  endtask

  task automatic random_phase(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 8) begin
        queue_sequence($urandom_range(stlb_pkg::JOINTS - 1));
        n = n + 7;
      end else begin
        pending_items.push_back(mk_item(stlb_pkg::op_t'(3'($urandom_range(7))),
                                        $urandom_range(stlb_pkg::JOINTS - 1),
                                        rand_value(), $urandom_range(1)));
        n = n + 1;
      end
      while (pending_items.size() > 20) @(posedge clk);
    end
    wait_drained();
  endtask

  initial begin
    stlb_pkg::result_t e;
    int directed_bad;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = stlb_pkg::CFG_BARRIER;
    cfg_data = '0;
    hold_off = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    barrier_q = stlb_pkg::BARRIER_RST;
    dt_q = stlb_pkg::STEP_RST;
    directed_bad = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fresh state gives zero outputs; zero divisor in condense
    // saturates; extremes of the value field; last clears the sum.
    add_row(mk_item(stlb_pkg::OP_AUGMENT, 0, 0, 1'b0), 1'b1, zero_res(0, 1'b0));
    add_row(mk_item(stlb_pkg::OP_NORM, 31, 0, 1'b0), 1'b1, zero_res(31, 1'b0));
    e = zero_res(1, 1'b1);
    e.diag_add = stlb_pkg::Q_MAX;
    e.grad_add = stlb_pkg::Q_MIN;   // -(MAX) - (MAX) clamps to MIN
    add_row(mk_item(stlb_pkg::OP_CONDENSE, 1, 0, 1'b0), 1'b1, e);
    add_row(mk_item(stlb_pkg::OP_LIMIT, 2, stlb_pkg::Q_MIN, 1'b0), 1'b0, e);
    e = zero_res(2, 1'b0);
    e.grad_add = -32'sd7;
    add_row(mk_item(stlb_pkg::OP_AUGMENT, 2, 0, 1'b0), 1'b1, e);
    add_row(mk_item(stlb_pkg::OP_LIMIT, 3, stlb_pkg::Q_MAX, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_SEED, 3, stlb_pkg::Q_MIN, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_LINEAR, 3, stlb_pkg::Q_MAX, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_UPDATE, 3, stlb_pkg::Q_MIN, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_CONDENSE, 3, 0, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_NORM, 3, stlb_pkg::Q_MIN, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_NORM, 2, stlb_pkg::Q_MAX, 1'b1), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_NONE, 31, -32'sd1, 1'b1), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_SEED, 4, 32'sh0001_0000, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_LINEAR, 4, 32'sh5555_5555, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_UPDATE, 4, 32'shaaaa_aaaa, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_CONDENSE, 4, 0, 1'b0), 1'b0, e);
    add_row(mk_item(stlb_pkg::OP_NORM, 4, 32'sh7fff_0000, 1'b1), 1'b0, e);

    // Walk the table one beat at a time so typed-in rows line up; every row
    // is also checked against the predictor by the result checker.
    foreach (table_rows[k]) begin
      pending_items.push_back(table_rows[k].it);
      wait_drained();
      if (table_rows[k].known && last_result !== table_rows[k].want) begin
        directed_bad = directed_bad + 1;
        if (mismatches + directed_bad <= 10)
          $display("row %0d: expected %p got %p", k, table_rows[k].want, last_result);
      end
    end

    // Config extremes, then the reset values, mixed with random traffic under two idling schemes.
    send_gap_pct = 6; recv_stall_pct = 50;
    write_reg(stlb_pkg::CFG_BARRIER, 31'd1);
    write_reg(stlb_pkg::CFG_STEP, 31'h7fff_ffff);
    random_phase(200);
    write_reg(stlb_pkg::CFG_BARRIER, 31'h7fff_ffff);
    write_reg(stlb_pkg::CFG_STEP, 31'd1);
    random_phase(150);

    send_gap_pct = 50; recv_stall_pct = 6;
    write_reg(stlb_pkg::CFG_BARRIER, 31'd66);
    write_reg(stlb_pkg::CFG_STEP, 31'd655);
    random_phase(400);

    // Long receiver hold-off while the sender keeps offering beats.
    send_gap_pct = 0; recv_stall_pct = 0;
    write_reg(stlb_pkg::CFG_BARRIER, 31'h0001_0000);
    write_reg(stlb_pkg::CFG_STEP, 31'h0000_4000);
    hold_off = 1'b1;
    wait (hold_left != 0);
    hold_off = 1'b0;
    random_phase(600);

    $display("run covered %0d beats, %0d results: every op, typed corner rows,",
             items_sent, results_seen);
    $display("register extremes, three idling mixes and a long output hold-off");
    if (mismatches == 0 && directed_bad == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d typed-row errors, %0d results missing", mismatches,
               directed_bad, expected_results.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/stlb_pkg.sv
design/stlb_divsqrt.sv
design/soft_torque_limit_barrier_unit.sv
tb/sv/soft_torque_limit_barrier_unit_test.sv
